FILE: rtl/assert_macros.svh
// assertion macros used by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("check failed");
`define CHK_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("check failed");
`else
`define CHK_IMPL(lbl, clk, rst, a, c)
`define CHK_NEXT(lbl, clk, rst, a, c)
`endif
`endif

FILE: rtl/anor_pkg.sv
// types and constants of the neighbor overlap range block
// no dependencies
package anor_pkg;
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_TOL  = 6'b000010,
    ST_RLO  = 6'b000100,
    ST_RHI  = 6'b001000,
    ST_SLO  = 6'b010000,
    ST_SHI  = 6'b100000
  } state_t;
  localparam int PosW = 48;
  localparam logic [1:0] AxisFirst = 2'd0;
  localparam logic [1:0] AxisLast  = 2'd2;
  // ceil(2^38 / 100): exact floor division by 100 for any 31-bit value
  localparam logic [31:0] Recip100   = 32'd2748779070;
  localparam int          RecipShift = 38;
endpackage

FILE: rtl/amr_neighbor_overlap_ranges.sv
// neighbor overlap ranges for a pair of mesh blocks, one item per axis
// s_axis takes an item, m_axis returns one result item per request
// tolerance = min cell / 100 by reciprocal multiply, registered in ST_TOL
// scans: each cell position is formed by a shared multiply-add unit
//   (one multiply, registered) and then compared; receive and send scans
//   each cover at most CELLS_PER_BLOCK+2*GHOST_CELLS steps plus their exit
//   compares; s_tready is low from accept until the result is registered and
//   rises as it is, so a new request is not taken before the last is through
// s_tdata, low bit up: axis[1:0] a_lo a_hi a_cell b_lo b_hi b_cell a_level b_level
// m_tdata, low bit up: axis_out side recv_start recv_end send_start send_end
//   contact_type level_diff; m_tlast carries last
// reset clears the sequencer, output valid and the touch count
// when m_tready is low the result holds in the output register and the next
// request is still taken; a finished scan waits in its last step until the
// output register is free
module amr_neighbor_overlap_ranges #(
  parameter int CELLS_PER_BLOCK = 16,
  parameter int GHOST_CELLS     = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [199:0] s_tdata,  // axis a_lo a_hi a_cell b_lo b_hi b_cell a_level b_level
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata,  // axis_out side recv_start recv_end send_start send_end ...
  output logic         m_tlast   // last
);
  import anor_pkg::*;
  `include "assert_macros.svh"
  localparam int IdxW = $clog2(CELLS_PER_BLOCK + 2*GHOST_CELLS + 1) + 2;
  localparam logic signed [IdxW-1:0] IdxMin = IdxW'(-GHOST_CELLS);
  localparam logic signed [IdxW-1:0] IdxMax = IdxW'(CELLS_PER_BLOCK + GHOST_CELLS);

  state_t state;
  logic [1:0]  axis;
  logic signed [31:0] a_lo, a_hi, b_lo, b_hi;
  logic [30:0] a_cell, b_cell;
  logic [3:0]  a_level, b_level;
  logic [30:0] cmin, quo;
  logic [62:0] tol_prod;
  logic signed [IdxW-1:0] ri_lo, ri_hi, si_lo, si_hi;
  logic        phase;
  logic [1:0]  touch, touch_base, touch_next;
  logic signed [PosW-1:0] rlo, rhi, pos, base, t2;
  logic signed [IdxW-1:0] idx;
  logic [30:0] csize;
  logic        out_v, out_free, done, finish;
  logic [39:0] out_data;
  logic        out_last;
  logic        is_last;
  logic [4:0]  ldiff;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_v;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;

  anor_pos_unit #(.IdxW(IdxW)) u_pos (
    .clk(clk), .idx(idx), .csize(csize), .base(base), .pos(pos)
  );

  assign tol_prod = cmin * Recip100;
  assign t2 = PosW'($signed({2'b0, quo})) <<< 1;
  always_comb begin
    idx   = ri_lo;
    csize = b_cell;
    base  = PosW'(b_lo) <<< 1;
    unique case (state)
      ST_RHI: idx = ri_hi - IdxW'(1);
      ST_SLO: begin idx = si_lo; csize = a_cell; base = PosW'(a_lo) <<< 1; end
      ST_SHI: begin idx = si_hi - IdxW'(1); csize = a_cell; base = PosW'(a_lo) <<< 1; end
      default: ;
    endcase
  end

  function automatic logic signed [32:0] absd(input logic signed [32:0] x);
    return x < 0 ? -x : x;
  endfunction

  logic signed [32:0] d1, d2, tq;
  logic [1:0] side_c;
  always_comb begin
    tq = $signed({2'b0, quo});
    d1 = absd(33'(a_hi) - 33'(b_lo));
    d2 = absd(33'(b_hi) - 33'(a_lo));
    side_c = (d1 < tq) ? 2'b01 : (d2 < tq) ? 2'b11 : 2'b00;
  end

  // count restarts on the first axis, saturates at three
  assign touch_base = (axis == AxisFirst) ? 2'd0 : touch;
  assign touch_next = (side_c != 2'b00 && touch_base != 2'd3) ? touch_base + 2'd1
                                                              : touch_base;
  assign is_last  = (axis == AxisLast);
  assign ldiff    = {1'b0, b_level} - {1'b0, a_level};
  assign done     = (ri_hi <= ri_lo) || (!phase && si_hi <= si_lo) ||
                    (phase && !(pos > rhi + t2));
  assign out_free = !out_v || m_tready;
  assign finish   = (state == ST_SHI) && done && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      touch <= 2'd0;
      phase <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: if (s_tvalid && s_tready) begin
          axis <= s_tdata[1:0];
          a_lo <= s_tdata[33:2];  a_hi <= s_tdata[65:34]; a_cell <= s_tdata[96:66];
          b_lo <= s_tdata[128:97]; b_hi <= s_tdata[160:129]; b_cell <= s_tdata[191:161];
          a_level <= s_tdata[195:192]; b_level <= s_tdata[199:196];
          cmin <= (s_tdata[96:66] < s_tdata[191:161]) ? s_tdata[96:66] : s_tdata[191:161];
          state <= ST_TOL;
        end
        ST_TOL: begin
          quo <= 31'(tol_prod[62:RecipShift]);
          state <= ST_RLO; phase <= 1'b0;
          ri_lo <= IdxMin; ri_hi <= IdxMax; si_lo <= IdxMin; si_hi <= IdxMax;
        end
        ST_RLO: begin
          if (!phase) begin
            if (ri_lo >= ri_hi) state <= ST_RHI;
            else phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            if (pos < ((PosW'(a_lo) <<< 1) - t2)) ri_lo <= ri_lo + IdxW'(1);
            else state <= ST_RHI;
          end
        end
        ST_RHI: begin
          if (!phase) begin
            if (ri_hi <= ri_lo) state <= ST_SLO;
            else phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            if (pos >= ((PosW'(a_hi) <<< 1) + t2)) ri_hi <= ri_hi - IdxW'(1);
            else state <= ST_SLO;
          end
        end
        ST_SLO: begin
          // on entry, an empty receive range empties the send range
          if (!phase) begin
            if (ri_hi <= ri_lo) begin
              si_lo <= '0; si_hi <= '0; state <= ST_SHI; phase <= 1'b1;
            end else if (si_lo >= si_hi) begin
              state <= ST_SHI; phase <= 1'b0;
            end else phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            if (pos < rlo - t2) si_lo <= si_lo + IdxW'(1);
            else state <= ST_SHI;
          end
        end
        ST_SHI: begin
          if (done) begin
            if (out_free) begin
              state <= ST_IDLE;
              touch <= touch_next;
              out_data <= {5'b0,
                           is_last ? ldiff : 5'd0,
                           is_last ? touch_next : 2'd0,
                           6'(si_hi), 6'(si_lo), 6'(ri_hi), 6'(ri_lo), side_c, axis};
              out_last <= is_last;
            end
          end else begin
            phase <= !phase;
            if (phase) si_hi <= si_hi - IdxW'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_v <= 1'b0;
    else if (finish) out_v <= 1'b1;
    else if (m_tready) out_v <= 1'b0;
  end

  // range end positions are captured from the shared unit during the receive scan compares
  always_ff @(posedge clk) begin
    if (state == ST_RLO && phase) rlo <= pos;
    if (state == ST_RHI && phase) rhi <= pos;
  end

  `CHK_IMPL(a_rdy_idle, clk, rst, s_tready, state == ST_IDLE)
  `CHK_NEXT(a_out_hold, clk, rst, out_v && !m_tready, out_v)
  `CHK_NEXT(a_data_hold, clk, rst, out_v && !m_tready, $stable(m_tdata))
  `CHK_IMPL(a_state_onehot, clk, rst, 1'b1, $onehot(state))
endmodule

FILE: rtl/anor_pos_unit.sv
// shared position unit: multiply odd index by cell size and add base
// depends on anor_pkg
module anor_pos_unit #(
  parameter int IdxW = 8
) (
  input  logic                          clk,
  input  logic signed [IdxW-1:0]        idx,
  input  logic [30:0]                   csize,
  input  logic signed [anor_pkg::PosW-1:0] base,
  output logic signed [anor_pkg::PosW-1:0] pos
);
  import anor_pkg::*;
  logic signed [IdxW:0]    odd;
  logic signed [IdxW+32:0] prod;
  // 2*idx+1 is the index with a one appended
  assign odd  = $signed({idx, 1'b1});
  assign prod = odd * $signed({1'b0, csize});
  always_ff @(posedge clk) begin
    pos <= base + PosW'(prod);
  end
endmodule
